[rtl/ipfpt_pkg.sv]
package ipfpt_pkg;

    // default sizing, handed to the top level parameters
    localparam int ENTRIES_DEF   = 32;
    localparam int MAX_FRAGS_DEF = 64;
    localparam int AGE_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 1'b1;

    localparam int          LIFE_W     = 16;
    localparam logic [15:0] LIFE_RESET = 16'd1000;

    // header constants
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam int          DF_BIT     = 14;
    localparam int          MF_BIT     = 13;
    localparam int          OFF_W      = 13;

    // result status codes
    localparam logic [2:0] STAT_COUNTED  = 3'd0;
    localparam logic [2:0] STAT_FILTERED = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_TOO_MANY = 3'd3;
    localparam logic [2:0] STAT_TICK     = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [47:0] link_addr;
        logic        outgoing;
        logic [15:0] ethertype;
        logic [7:0]  ip_protocol;
        logic [15:0] frag_word;
        logic [15:0] ip_ident;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] frame_len;
    } t_in;

    typedef struct packed {
        logic        counted;
        logic [2:0]  status;
        logic        upload;
        logic [31:0] host_addr;
        logic [31:0] peer_addr;
        logic [15:0] host_port;
        logic [15:0] peer_port;
        logic [15:0] record_len;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FREE_SCAN,
        S_MATCH_SCAN,
        S_TICK_SCAN,
        S_EMIT
    } t_state;

    // result that carries no traffic record
    function automatic t_out blank_res(input logic [2:0] status);
        t_out r;
        r        = '0;
        r.status = status;
        return r;
    endfunction

    // traffic record oriented by direction
    function automatic t_out counted_res(input t_in f, input logic [15:0] sp,
                                         input logic [15:0] dp);
        t_out r;
        r            = '0;
        r.counted    = 1'b1;
        r.status     = STAT_COUNTED;
        r.upload     = f.outgoing;
        r.record_len = f.frame_len;
        if (f.outgoing) begin
            r.host_addr = f.src_addr;
            r.peer_addr = f.dst_addr;
            r.host_port = sp;
            r.peer_port = dp;
        end else begin
            r.host_addr = f.dst_addr;
            r.peer_addr = f.src_addr;
            r.host_port = dp;
            r.peer_port = sp;
        end
        return r;
    endfunction

endpackage

[rtl/ipfpt_entry_ram.sv]
module ipfpt_entry_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ip_fragment_port_tracker.sv]
// IPv4 fragment port tracker. Each input beat is either the parsed header of one captured
// frame or an ageing tick; each gives exactly one result beat. Loopback, non-IPv4 and
// frames of the protocol not selected by udp_mode come back as filtered. A first fragment
// claims the lowest free table entry and stores its id and ports; later fragments are looked
// up by IP id and reported with the stored ports, the last one freeing the entry. The table
// lives in a one-port-read, one-port-write RAM with a registered read port, plus a
// valid flag per entry that reset clears, so no clearing pass is needed after reset.
// Timing: one item at a time. First fragments check one valid flag per cycle; later
// fragments and ticks do one RAM read per cycle, with compare and write-back in the cycle
// after the read. The result sits in an output register, so a new beat is taken while
// the previous result still waits for the consumer. Configuration writes are expected
// only while the block is idle.
module ip_fragment_port_tracker #(
    parameter int ENTRIES   = ipfpt_pkg::ENTRIES_DEF,
    parameter int MAX_FRAGS = ipfpt_pkg::MAX_FRAGS_DEF,
    parameter int AGE_WIDTH = ipfpt_pkg::AGE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ipfpt_pkg::t_in                 i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ipfpt_pkg::t_out                o_out,
    input  logic                           i_cfg_we,
    input  logic [ipfpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ipfpt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ipfpt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAGS + 1);
    // entry word: {ident, src_port, dst_port, frag_count, age}
    localparam int ENT_W = 48 + CNT_W + AGE_WIDTH;
    localparam int CMP_W = (AGE_WIDTH > LIFE_W) ? AGE_WIDTH : LIFE_W;
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]     MAX_CNT  = CNT_W'(MAX_FRAGS);
    localparam logic [AGE_WIDTH-1:0] AGE_MAX  = {AGE_WIDTH{1'b1}};

    // configuration
    logic              r_udp_mode;
    logic [LIFE_W-1:0] r_lifetime;

    // sequencer
    t_state           r_state, n_state;
    t_in              r_in;
    t_out             r_res, n_res;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_rd_done, n_rd_done;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;

    // output register
    t_out r_out;
    logic r_out_vld;
    logic out_free;

    // entry table
    logic [ENTRIES-1:0] r_valid;
    logic               set_en;
    logic               clr_en;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ENT_W-1:0]   rd_data;

    logic [15:0]          rd_ident, rd_sp, rd_dp;
    logic [CNT_W-1:0]     rd_cnt;
    logic [AGE_WIDTH-1:0] rd_age, age_inc;
    logic [7:0]           want_proto;
    logic                 cmp_entry_valid;

    assign rd_age   = rd_data[AGE_WIDTH-1:0];
    assign rd_cnt   = rd_data[AGE_WIDTH +: CNT_W];
    assign rd_dp    = rd_data[AGE_WIDTH+CNT_W +: 16];
    assign rd_sp    = rd_data[AGE_WIDTH+CNT_W+16 +: 16];
    assign rd_ident = rd_data[AGE_WIDTH+CNT_W+32 +: 16];

    // saturating age step for ticks
    assign age_inc = (rd_age == AGE_MAX) ? rd_age : rd_age + 1'b1;

    assign want_proto      = r_udp_mode ? PROTO_UDP : PROTO_TCP;
    assign cmp_entry_valid = r_valid[r_cmp_idx];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign out_free    = !r_out_vld || i_out_ready;

    ipfpt_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_udp_mode <= 1'b0;
            r_lifetime <= LIFE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UDP_MODE: r_udp_mode <= i_cfg_data[0];
                CFG_LIFETIME: r_lifetime <= i_cfg_data[LIFE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_done <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_done <= n_rd_done;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // payload and scan pointers
    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // entry valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (set_en) begin
                r_valid[r_rd_idx] <= 1'b1;
            end
            if (clr_en) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
        end
    end

    // output register: holds the result while the next beat is being worked on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    // next state, table access and result
    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_rd_idx  = r_rd_idx;
        n_rd_done = r_rd_done;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        ram_we    = 1'b0;
        ram_waddr = r_cmp_idx;
        ram_wdata = rd_data;
        ram_re    = 1'b0;
        set_en    = 1'b0;
        clr_en    = 1'b0;

        // read stream for the RAM scans: one address per cycle, compare in the cycle after the read
        if ((r_state == S_MATCH_SCAN || r_state == S_TICK_SCAN) && !r_rd_done) begin
            ram_re    = 1'b1;
            n_cmp_vld = 1'b1;
            n_cmp_idx = r_rd_idx;
            if (r_rd_idx == LAST_IDX) begin
                n_rd_done = 1'b1;
            end else begin
                n_rd_idx = r_rd_idx + 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_rd_idx  = '0;
                n_rd_done = 1'b0;
                if (r_in.kind) begin
                    n_state = S_TICK_SCAN;
                end else if (r_in.link_addr == '0 || r_in.ethertype != ETYPE_IPV4 ||
                             r_in.ip_protocol != want_proto) begin
                    n_res   = blank_res(STAT_FILTERED);
                    n_state = S_EMIT;
                end else if (r_in.frag_word[DF_BIT]) begin
                    // don't-fragment frames keep their own ports
                    n_res   = counted_res(r_in, r_in.src_port, r_in.dst_port);
                    n_state = S_EMIT;
                end else if (r_in.frag_word[MF_BIT] && r_in.frag_word[OFF_W-1:0] == '0) begin
                    n_state = S_FREE_SCAN;
                end else if (r_in.frag_word[OFF_W-1:0] != '0) begin
                    n_state = S_MATCH_SCAN;
                end else begin
                    n_res   = counted_res(r_in, r_in.src_port, r_in.dst_port);
                    n_state = S_EMIT;
                end
            end

            // first fragment: lowest free entry, one flag per cycle
            S_FREE_SCAN: begin
                if (!r_valid[r_rd_idx]) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_idx;
                    ram_wdata = {r_in.ip_ident, r_in.src_port, r_in.dst_port,
                                 CNT_W'(1), {AGE_WIDTH{1'b0}}};
                    set_en    = 1'b1;
                    n_res     = counted_res(r_in, r_in.src_port, r_in.dst_port);
                    n_state   = S_EMIT;
                end else if (r_rd_idx == LAST_IDX) begin
                    n_res   = blank_res(STAT_FULL);
                    n_state = S_EMIT;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end

            // later fragment: first valid entry with the same id wins
            S_MATCH_SCAN: begin
                if (r_cmp_vld) begin
                    if (cmp_entry_valid && rd_ident == r_in.ip_ident) begin
                        if (rd_cnt >= MAX_CNT) begin
                            n_res = blank_res(STAT_TOO_MANY);
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {rd_ident, rd_sp, rd_dp, rd_cnt + 1'b1, rd_age};
                            clr_en    = !r_in.frag_word[MF_BIT];
                            n_res     = counted_res(r_in, rd_sp, rd_dp);
                        end
                        n_state = S_EMIT;
                    end else if (r_cmp_idx == LAST_IDX) begin
                        // no entry: own port words are reported
                        n_res   = counted_res(r_in, r_in.src_port, r_in.dst_port);
                        n_state = S_EMIT;
                    end
                end
            end

            // ageing sweep over every entry
            S_TICK_SCAN: begin
                if (r_cmp_vld) begin
                    if (cmp_entry_valid) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_data[ENT_W-1:AGE_WIDTH], age_inc};
                        clr_en    = (CMP_W'(age_inc) >= CMP_W'(r_lifetime));
                    end
                    if (r_cmp_idx == LAST_IDX) begin
                        n_res   = blank_res(STAT_TICK);
                        n_state = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
